FILE: design/tspd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspd_pkg
// Types and constants shared by the tape save pulse decoder.
// ----------------------------------------------------------------------------
package tspd_pkg;

    localparam int unsigned DATA_CAPACITY = 65536;
    localparam int unsigned MAX_BLOCKS    = 256;

    localparam logic [15:0] PILOT_COUNT_MAX = 16'hffff;
    localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

    typedef enum logic [2:0] {
        REG_BIT_ZERO   = 3'd0,
        REG_BIT_ONE    = 3'd1,
        REG_PILOT      = 3'd2,
        REG_SYNC1      = 3'd3,
        REG_SYNC2      = 3'd4,
        REG_END_SYNC   = 3'd5,
        REG_TOLERANCE  = 3'd6,
        REG_MIN_PILOT  = 3'd7
    } t_reg_index;

    typedef enum logic [3:0] {
        CL_NONE  = 4'd0,
        CL_BIT0  = 4'd1,
        CL_BIT1  = 4'd2,
        CL_PILOT = 4'd3,
        CL_SYNC1 = 4'd4,
        CL_SYNC2 = 4'd5,
        CL_END   = 4'd6,
        CL_SHORT = 4'd7,
        CL_LONG  = 4'd8
    } t_pulse_class;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PILOT = 3'd1,
        PH_SYNC1 = 3'd2,
        PH_SYNC2 = 3'd3,
        PH_DATA  = 3'd4,
        PH_ERROR = 3'd5
    } t_phase;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_LEVEL = 1'b1
    } t_action;

    typedef struct packed {
        logic        action;
        logic        mic_level;
        logic [31:0] time_tacts;
    } t_in_word;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  data_byte;
        logic [15:0] byte_address;
        logic        block_done;
        logic [7:0]  block_index;
        logic [16:0] block_offset;
        logic [16:0] block_length;
        logic [3:0]  pulse_class;
        logic [2:0]  phase;
        logic        data_overflow;
        logic        block_overflow;
    } t_out_word;

endpackage
`default_nettype wire

FILE: design/tape_save_pulse_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// The result word of an accepted input word is registered in the result register.
// Throughput: one word per cycle unless stalled; classification and the phase
// update are a single combinational pass into the state and result registers.
// Reset (synchronous, active low) restores the register defaults, clears
// the capture state and the sticky overflow flags, and empties the output.
// ----------------------------------------------------------------------------
// tape_save_pulse_decoder
// Measures pulses on the tape output level and decodes pilot, sync and data
// into bytes and closed blocks.
// ----------------------------------------------------------------------------
module tape_save_pulse_decoder (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire tspd_pkg::t_in_word i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output tspd_pkg::t_out_word  o_out_word,
    input  wire                  i_cfg_we,
    input  wire  [2:0]           i_cfg_index,
    input  wire  [15:0]          i_cfg_data
);

    // Configuration registers.
    logic [15:0] r_bit_zero, r_bit_one, r_pilot, r_sync1, r_sync2, r_end_sync;
    logic [11:0] r_tol;
    logic [15:0] r_min_pilot;

    // Capture state.
    logic                   r_capturing,   n_capturing;
    logic                   r_level_seen,  n_level_seen;
    logic [31:0]            r_last_edge,   n_last_edge;
    tspd_pkg::t_phase       r_phase,       n_phase;
    tspd_pkg::t_pulse_class r_pending,     n_pending;
    tspd_pkg::t_pulse_class r_last_class,  n_last_class;
    logic [15:0]            r_pilot_count, n_pilot_count;
    logic [3:0]             r_bit_count,   n_bit_count;
    logic [7:0]             r_shift,       n_shift;
    logic [16:0]            r_stored_bytes, n_stored_bytes;
    logic [8:0]             r_stored_blocks, n_stored_blocks;
    logic [16:0]            r_open_offset, n_open_offset;
    logic [16:0]            r_open_length, n_open_length;
    logic                   r_data_ovf,    n_data_ovf;
    logic                   r_block_ovf,   n_block_ovf;

    logic                   r_out_valid;
    tspd_pkg::t_out_word    r_out_word, n_out_word;

    logic                   in_accept;
    logic [31:0]            pulse_len;
    tspd_pkg::t_pulse_class pulse_cls;
    logic [3:0]             bit_count_inc;
    logic [7:0]             shift_inc;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign pulse_len = i_in_word.time_tacts - r_last_edge;

    // Symmetric tolerance window; the lower bound floors at zero.
    function automatic logic in_window(input logic [31:0] len, input logic [15:0] nom,
                                       input logic [11:0] tol);
        logic [16:0] lo;
        logic [16:0] hi;
        begin
            lo = ({1'b0, nom} > {5'd0, tol}) ? ({1'b0, nom} - {5'd0, tol}) : 17'd0;
            hi = {1'b0, nom} + {5'd0, tol};
            in_window = (len >= {15'd0, lo}) && (len <= {15'd0, hi});
        end
    endfunction

    always_comb begin
        logic [17:0] long_limit;
        long_limit = {2'b00, r_pilot} + {5'd0, r_tol, 1'b0};
        if (in_window(pulse_len, r_bit_zero, r_tol)) begin
            pulse_cls = tspd_pkg::CL_BIT0;
        end else if (in_window(pulse_len, r_bit_one, r_tol)) begin
            pulse_cls = tspd_pkg::CL_BIT1;
        end else if (in_window(pulse_len, r_pilot, r_tol)) begin
            pulse_cls = tspd_pkg::CL_PILOT;
        end else if (in_window(pulse_len, r_sync1, r_tol)) begin
            pulse_cls = tspd_pkg::CL_SYNC1;
        end else if (in_window(pulse_len, r_sync2, r_tol)) begin
            pulse_cls = tspd_pkg::CL_SYNC2;
        end else if (in_window(pulse_len, r_end_sync, r_tol)) begin
            pulse_cls = tspd_pkg::CL_END;
        end else if (({4'd0, r_sync1} > {8'd0, r_tol}) &&
                     (pulse_len < {16'd0, r_sync1 - {4'd0, r_tol}})) begin
            pulse_cls = tspd_pkg::CL_SHORT;
        end else if (pulse_len > {14'd0, long_limit}) begin
            pulse_cls = tspd_pkg::CL_LONG;
        end else begin
            pulse_cls = tspd_pkg::CL_NONE;
        end
    end

    assign bit_count_inc = r_bit_count + 4'd1;
    assign shift_inc     = {r_shift[6:0], (pulse_cls == tspd_pkg::CL_BIT1)};

    always_comb begin
        n_capturing     = r_capturing;
        n_level_seen    = r_level_seen;
        n_last_edge     = r_last_edge;
        n_phase         = r_phase;
        n_pending       = r_pending;
        n_last_class    = r_last_class;
        n_pilot_count   = r_pilot_count;
        n_bit_count     = r_bit_count;
        n_shift         = r_shift;
        n_stored_bytes  = r_stored_bytes;
        n_stored_blocks = r_stored_blocks;
        n_open_offset   = r_open_offset;
        n_open_length   = r_open_length;
        n_data_ovf      = r_data_ovf;
        n_block_ovf     = r_block_ovf;
        n_out_word      = '0;

        if (i_in_word.action == tspd_pkg::ACT_START) begin
            n_capturing     = 1'b1;
            n_level_seen    = 1'b1;
            n_last_edge     = i_in_word.time_tacts;
            n_phase         = tspd_pkg::PH_IDLE;
            n_pending       = tspd_pkg::CL_NONE;
            n_last_class    = tspd_pkg::CL_NONE;
            n_pilot_count   = '0;
            n_bit_count     = '0;
            n_shift         = '0;
            n_stored_bytes  = '0;
            n_stored_blocks = '0;
            n_open_offset   = '0;
            n_open_length   = '0;
        end else if (r_capturing && (i_in_word.mic_level != r_level_seen)) begin
            n_level_seen = i_in_word.mic_level;
            n_last_edge  = i_in_word.time_tacts;
            n_last_class = pulse_cls;
            n_phase      = tspd_pkg::PH_ERROR;

            case (r_phase)
                tspd_pkg::PH_IDLE: begin
                    if (pulse_cls inside {tspd_pkg::CL_SHORT, tspd_pkg::CL_LONG}) begin
                        n_phase = tspd_pkg::PH_IDLE;
                    end else if (pulse_cls == tspd_pkg::CL_PILOT) begin
                        n_pilot_count = 16'd1;
                        n_phase       = tspd_pkg::PH_PILOT;
                    end
                end
                tspd_pkg::PH_PILOT: begin
                    if (pulse_cls == tspd_pkg::CL_PILOT) begin
                        if (r_pilot_count != tspd_pkg::PILOT_COUNT_MAX) begin
                            n_pilot_count = r_pilot_count + 16'd1;
                        end
                        n_phase = tspd_pkg::PH_PILOT;
                    end else if (pulse_cls == tspd_pkg::CL_SYNC1 &&
                                 r_pilot_count >= r_min_pilot) begin
                        n_phase = tspd_pkg::PH_SYNC1;
                    end
                end
                tspd_pkg::PH_SYNC1: begin
                    if (pulse_cls == tspd_pkg::CL_SYNC2) begin
                        n_phase = tspd_pkg::PH_SYNC2;
                    end
                end
                tspd_pkg::PH_SYNC2: begin
                    if (pulse_cls inside {tspd_pkg::CL_BIT0, tspd_pkg::CL_BIT1}) begin
                        n_pending     = pulse_cls;
                        n_bit_count   = '0;
                        n_shift       = '0;
                        n_open_offset = r_stored_bytes;
                        n_open_length = '0;
                        n_phase       = tspd_pkg::PH_DATA;
                    end
                end
                tspd_pkg::PH_DATA: begin
                    if (pulse_cls inside {tspd_pkg::CL_BIT0, tspd_pkg::CL_BIT1}) begin
                        if (r_pending == tspd_pkg::CL_NONE) begin
                            n_pending = pulse_cls;
                            n_phase   = tspd_pkg::PH_DATA;
                        end else if (r_pending == pulse_cls) begin
                            // Second matching half-pulse: one bit is complete.
                            n_pending   = tspd_pkg::CL_NONE;
                            n_phase     = tspd_pkg::PH_DATA;
                            n_bit_count = bit_count_inc;
                            n_shift     = shift_inc;
                            if (bit_count_inc == tspd_pkg::BITS_PER_BYTE) begin
                                if (r_stored_bytes >=
                                    17'(tspd_pkg::DATA_CAPACITY)) begin
                                    n_data_ovf = 1'b1;
                                    n_phase    = tspd_pkg::PH_ERROR;
                                end else begin
                                    n_out_word.byte_valid   = 1'b1;
                                    n_out_word.data_byte    = shift_inc;
                                    n_out_word.byte_address = r_stored_bytes[15:0];
                                    n_stored_bytes = r_stored_bytes + 17'd1;
                                    n_open_length  = r_open_length + 17'd1;
                                    n_shift        = '0;
                                    n_bit_count    = '0;
                                end
                            end
                        end
                    end else if (pulse_cls == tspd_pkg::CL_END) begin
                        if (r_stored_blocks >= 9'(tspd_pkg::MAX_BLOCKS)) begin
                            n_block_ovf = 1'b1;
                            n_phase     = tspd_pkg::PH_ERROR;
                        end else begin
                            n_out_word.block_done   = 1'b1;
                            n_out_word.block_index  = r_stored_blocks[7:0];
                            n_out_word.block_offset = r_open_offset;
                            n_out_word.block_length = r_open_length;
                            n_stored_blocks = r_stored_blocks + 9'd1;
                            n_phase         = tspd_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = tspd_pkg::PH_ERROR;
                end
            endcase
        end

        n_out_word.pulse_class    = n_last_class;
        n_out_word.phase          = n_phase;
        n_out_word.data_overflow  = n_data_ovf;
        n_out_word.block_overflow = n_block_ovf;
    end

    // Configuration write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_zero  <= 16'd855;
            r_bit_one   <= 16'd1710;
            r_pilot     <= 16'd2168;
            r_sync1     <= 16'd667;
            r_sync2     <= 16'd735;
            r_end_sync  <= 16'd945;
            r_tol       <= 12'd100;
            r_min_pilot <= 16'd256;
        end else if (i_cfg_we) begin
            case (tspd_pkg::t_reg_index'(i_cfg_index))
                tspd_pkg::REG_BIT_ZERO:  r_bit_zero  <= i_cfg_data;
                tspd_pkg::REG_BIT_ONE:   r_bit_one   <= i_cfg_data;
                tspd_pkg::REG_PILOT:     r_pilot     <= i_cfg_data;
                tspd_pkg::REG_SYNC1:     r_sync1     <= i_cfg_data;
                tspd_pkg::REG_SYNC2:     r_sync2     <= i_cfg_data;
                tspd_pkg::REG_END_SYNC:  r_end_sync  <= i_cfg_data;
                tspd_pkg::REG_TOLERANCE: r_tol       <= i_cfg_data[11:0];
                tspd_pkg::REG_MIN_PILOT: r_min_pilot <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing     <= 1'b0;
            r_level_seen    <= 1'b1;
            r_last_edge     <= '0;
            r_phase         <= tspd_pkg::PH_IDLE;
            r_pending       <= tspd_pkg::CL_NONE;
            r_last_class    <= tspd_pkg::CL_NONE;
            r_pilot_count   <= '0;
            r_bit_count     <= '0;
            r_shift         <= '0;
            r_stored_bytes  <= '0;
            r_stored_blocks <= '0;
            r_open_offset   <= '0;
            r_open_length   <= '0;
            r_data_ovf      <= 1'b0;
            r_block_ovf     <= 1'b0;
        end else if (in_accept) begin
            r_capturing     <= n_capturing;
            r_level_seen    <= n_level_seen;
            r_last_edge     <= n_last_edge;
            r_phase         <= n_phase;
            r_pending       <= n_pending;
            r_last_class    <= n_last_class;
            r_pilot_count   <= n_pilot_count;
            r_bit_count     <= n_bit_count;
            r_shift         <= n_shift;
            r_stored_bytes  <= n_stored_bytes;
            r_stored_blocks <= n_stored_blocks;
            r_open_offset   <= n_open_offset;
            r_open_length   <= n_open_length;
            r_data_ovf      <= n_data_ovf;
            r_block_ovf     <= n_block_ovf;
        end
    end

    // Result register: a new word may load in the cycle the old one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
`default_nettype wire
